@@ hw/rtl/clns_pkg.sv @@
package clns_pkg;

    localparam int unsigned CFG_WIDTH   = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned HOLD_W      = 17;
    localparam int unsigned PC_W        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_GAP   = 3'd4;

    localparam logic [CFG_WIDTH-1:0] CLEAR_WAIT_RST   = 16'd2000;
    localparam logic [CFG_WIDTH-1:0] COMMAND_WAIT_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] INIT_WAIT_RST    = 16'd40;
    localparam logic [CFG_WIDTH-1:0] FIRST_GAP_RST    = 16'd5000;
    localparam logic [CFG_WIDTH-1:0] SECOND_GAP_RST   = 16'd1000;

    localparam logic [2:0] FUNC_COMMAND     = 3'd0;
    localparam logic [2:0] FUNC_CHAR        = 3'd1;
    localparam logic [2:0] FUNC_INIT_NIBBLE = 3'd2;
    localparam logic [2:0] FUNC_CURSOR      = 3'd3;
    localparam logic [2:0] FUNC_CURSOR_CHAR = 3'd4;
    localparam logic [2:0] FUNC_POWER_UP    = 3'd5;

    localparam logic [7:0] BASE_FIRST_LINE  = 8'h80;
    localparam logic [7:0] BASE_SECOND_LINE = 8'hC0;
    localparam logic [7:0] CLEAR_LIMIT      = 8'h02;
    localparam logic [1:0] ROW_FIRST        = 2'd1;

    localparam logic [PC_W-1:0] ENTRY_COMMAND  = 4'd0;
    localparam logic [PC_W-1:0] ENTRY_CHAR     = 4'd2;
    localparam logic [PC_W-1:0] ENTRY_INIT     = 4'd4;
    localparam logic [PC_W-1:0] ENTRY_POWER_UP = 4'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] col;
    } clns_in_t;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              reg_select;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } clns_out_t;

    typedef enum logic [2:0] {
        NS_OPA_HI,
        NS_OPA_LO,
        NS_BYTE_HI,
        NS_BYTE_LO,
        NS_CONST
    } nib_sel_t;

    typedef enum logic [2:0] {
        HS_ZERO,
        HS_AUTO,
        HS_COMMAND,
        HS_CLEAR,
        HS_INIT,
        HS_INIT_FIRST,
        HS_INIT_SECOND
    } hold_sel_t;

    typedef enum logic [1:0] {
        FL_NEXT,
        FL_END,
        FL_BR_CHAIN
    } flow_t;

    typedef struct packed {
        nib_sel_t        nib_sel;
        logic [3:0]      const_nib;
        logic            reg_select;
        hold_sel_t       hold_sel;
        flow_t           flow;
        logic [PC_W-1:0] target;
    } uctl_t;

endpackage

@@ hw/rtl/clns_urom.sv @@
module clns_urom (
    input  logic [clns_pkg::PC_W-1:0] pc,
    output clns_pkg::uctl_t           ctl
);
    import clns_pkg::*;

    function automatic uctl_t uw(nib_sel_t ns, logic [3:0] cn, logic rs, hold_sel_t hs,
                                 flow_t fl, logic [PC_W-1:0] tg);
        uctl_t w;
        w.nib_sel    = ns;
        w.const_nib  = cn;
        w.reg_select = rs;
        w.hold_sel   = hs;
        w.flow       = fl;
        w.target     = tg;
        return w;
    endfunction

    always_comb
    begin
        unique case (pc)
            4'd0:    ctl = uw(NS_OPA_HI,  4'h0, 1'b0, HS_ZERO,        FL_NEXT,     4'd0);
            4'd1:    ctl = uw(NS_OPA_LO,  4'h0, 1'b0, HS_AUTO,        FL_BR_CHAIN, ENTRY_CHAR);
            4'd2:    ctl = uw(NS_BYTE_HI, 4'h0, 1'b1, HS_ZERO,        FL_NEXT,     4'd0);
            4'd3:    ctl = uw(NS_BYTE_LO, 4'h0, 1'b1, HS_COMMAND,     FL_END,      4'd0);
            4'd4:    ctl = uw(NS_BYTE_HI, 4'h0, 1'b0, HS_INIT,        FL_END,      4'd0);
            4'd5:    ctl = uw(NS_CONST,   4'h3, 1'b0, HS_INIT_FIRST,  FL_NEXT,     4'd0);
            4'd6:    ctl = uw(NS_CONST,   4'h3, 1'b0, HS_INIT_SECOND, FL_NEXT,     4'd0);
            4'd7:    ctl = uw(NS_CONST,   4'h3, 1'b0, HS_INIT,        FL_NEXT,     4'd0);
            4'd8:    ctl = uw(NS_CONST,   4'h2, 1'b0, HS_INIT,        FL_NEXT,     4'd0);
            4'd9:    ctl = uw(NS_CONST,   4'h2, 1'b0, HS_ZERO,        FL_NEXT,     4'd0);
            4'd10:   ctl = uw(NS_CONST,   4'h8, 1'b0, HS_COMMAND,     FL_NEXT,     4'd0);
            4'd11:   ctl = uw(NS_CONST,   4'h0, 1'b0, HS_ZERO,        FL_NEXT,     4'd0);
            4'd12:   ctl = uw(NS_CONST,   4'h1, 1'b0, HS_CLEAR,       FL_NEXT,     4'd0);
            4'd13:   ctl = uw(NS_CONST,   4'h0, 1'b0, HS_ZERO,        FL_NEXT,     4'd0);
            4'd14:   ctl = uw(NS_CONST,   4'hE, 1'b0, HS_COMMAND,     FL_END,      4'd0);
            default: ctl = uw(NS_CONST,   4'h0, 1'b0, HS_ZERO,        FL_END,      4'd0);
        endcase
    end

endmodule

@@ hw/rtl/char_lcd_nibble_sequencer.sv @@
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | in_data  : func, byte_value, row, col
// out      | out_valid / out_stall  | out_data : nibble, reg_select, hold_us, last
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// A request is loaded into registers, then the microcode table issues one pulse per cycle
// while out_stall does not hold the output; the program for its func sets how many pulses;
// func 6 and 7 issue no pulses.
// A new request is taken once the last pulse of the previous one has issued.
// Reset restores the default hold registers and empties the output register.
// out_stall, while out_valid is high, holds the output register and freezes the step counter.
module char_lcd_nibble_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  clns_pkg::clns_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output clns_pkg::clns_out_t               out_data,
    input  logic                              cfg_we,
    input  logic [clns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [clns_pkg::CFG_WIDTH-1:0]    cfg_data
);
    import clns_pkg::*;

    logic [CFG_WIDTH-1:0] clear_wait_reg;
    logic [CFG_WIDTH-1:0] command_wait_reg;
    logic [CFG_WIDTH-1:0] init_wait_reg;
    logic [CFG_WIDTH-1:0] first_gap_reg;
    logic [CFG_WIDTH-1:0] second_gap_reg;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            chain_reg, chain_next;
    logic [7:0]      opa_reg, opa_next;
    logic [7:0]      byte_reg, byte_next;
    logic            out_valid_reg, out_valid_next;
    clns_out_t       out_reg, out_next;

    uctl_t           ctl;
    logic            accept;
    logic            issue;
    logic            start;
    logic [PC_W-1:0] entry;
    logic [7:0]      cursor_addr;
    logic [7:0]      base;
    logic [3:0]      nib;
    logic [HOLD_W-1:0] hold;
    logic            is_last;

    clns_urom u_urom (
        .pc  (pc_reg),
        .ctl (ctl)
    );

    assign in_stall  = busy_reg;
    assign accept    = in_valid && !busy_reg;
    assign issue     = busy_reg && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign base        = (in_data.row == ROW_FIRST) ? BASE_FIRST_LINE : BASE_SECOND_LINE;
    assign cursor_addr = base + {2'b00, in_data.col} - 8'd1;

    always_comb
    begin
        start = 1'b1;
        entry = ENTRY_COMMAND;
        unique case (in_data.func) inside
            FUNC_COMMAND, FUNC_CURSOR, FUNC_CURSOR_CHAR: entry = ENTRY_COMMAND;
            FUNC_CHAR:                                   entry = ENTRY_CHAR;
            FUNC_INIT_NIBBLE:                            entry = ENTRY_INIT;
            FUNC_POWER_UP:                               entry = ENTRY_POWER_UP;
            default:                                     start = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (ctl.nib_sel)
            NS_OPA_HI:  nib = opa_reg[7:4];
            NS_OPA_LO:  nib = opa_reg[3:0];
            NS_BYTE_HI: nib = byte_reg[7:4];
            NS_BYTE_LO: nib = byte_reg[3:0];
            NS_CONST:   nib = ctl.const_nib;
            default:    nib = ctl.const_nib;
        endcase
    end

    always_comb
    begin
        unique case (ctl.hold_sel)
            HS_ZERO:        hold = '0;
            HS_AUTO:        hold = (opa_reg <= CLEAR_LIMIT) ? {1'b0, clear_wait_reg}
                                                            : {1'b0, command_wait_reg};
            HS_COMMAND:     hold = {1'b0, command_wait_reg};
            HS_CLEAR:       hold = {1'b0, clear_wait_reg};
            HS_INIT:        hold = {1'b0, init_wait_reg};
            HS_INIT_FIRST:  hold = {1'b0, init_wait_reg} + {1'b0, first_gap_reg};
            HS_INIT_SECOND: hold = {1'b0, init_wait_reg} + {1'b0, second_gap_reg};
            default:        hold = '0;
        endcase
    end

    assign is_last = (ctl.flow == FL_END) || ((ctl.flow == FL_BR_CHAIN) && !chain_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        chain_next     = chain_reg;
        opa_next       = opa_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next  = start;
            pc_next    = entry;
            chain_next = (in_data.func == FUNC_CURSOR_CHAR);
            opa_next   = (in_data.func == FUNC_COMMAND) ? in_data.byte_value : cursor_addr;
            byte_next  = in_data.byte_value;
        end
        else if (issue)
        begin
            out_valid_next      = 1'b1;
            out_next.nibble     = nib;
            out_next.reg_select = ctl.reg_select;
            out_next.hold_us    = hold;
            out_next.last       = is_last;
            unique case (ctl.flow)
                FL_NEXT:     pc_next = pc_reg + 4'd1;
                FL_BR_CHAIN:
                begin
                    pc_next    = ctl.target;
                    chain_next = 1'b0;
                    busy_next  = chain_reg;
                end
                FL_END:      busy_next = 1'b0;
                default:     busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            chain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_wait_reg   <= CLEAR_WAIT_RST;
            command_wait_reg <= COMMAND_WAIT_RST;
            init_wait_reg    <= INIT_WAIT_RST;
            first_gap_reg    <= FIRST_GAP_RST;
            second_gap_reg   <= SECOND_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLEAR_WAIT:   clear_wait_reg   <= cfg_data;
                REG_COMMAND_WAIT: command_wait_reg <= cfg_data;
                REG_INIT_WAIT:    init_wait_reg    <= cfg_data;
                REG_FIRST_GAP:    first_gap_reg    <= cfg_data;
                REG_SECOND_GAP:   second_gap_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule
